### hdl/integer_to_ascii_digits_core_defines.svh
// Assertion macros shared by the integer-to-ASCII converter RTL.
// Included by integer_to_ascii_digits_core, the module that carries concurrent assertions; no other dependencies.
`ifndef INTEGER_TO_ASCII_DIGITS_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_DIGITS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/itad_pkg.sv
// Shared constants and the digit-to-character function of the integer-to-ASCII converter.
// No dependencies; used by itad_div and integer_to_ascii_digits_core.
`default_nettype none

package itad_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 5;
  localparam int DIGIT_W         = 4;
  localparam int CHAR_W          = 7;
  localparam int OUT_W           = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // Maps a digit value to 0-9 or upper-case A-F.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < DIGIT_W'(10)) begin
      digit_char = CHAR_ZERO + ext;
    end else begin
      digit_char = CHAR_UPPER + ext - CHAR_W'(10);
    end
  endfunction

endpackage

`default_nettype wire

### hdl/itad_div.sv
// Restoring divider of a VALUE_WIDTH-bit value by a base of 2 to 16, one quotient bit per cycle.
// Depends on itad_pkg for field widths.
`default_nettype none

module itad_div #(
  parameter int VALUE_WIDTH = itad_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [VALUE_WIDTH-1:0]           dividend,
  input  wire logic [itad_pkg::RADIX_W-1:0]     divisor,
  output logic                                  done,
  output logic [VALUE_WIDTH-1:0]                quotient,
  output logic [itad_pkg::DIGIT_W-1:0]          remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);

  logic                            busy_r,  busy_nxt;
  logic                            done_r,  done_nxt;
  logic [CNT_W-1:0]                cnt_r,   cnt_nxt;
  logic [VALUE_WIDTH-1:0]          quo_r,   quo_nxt;
  logic [itad_pkg::DIGIT_W-1:0]    rem_r,   rem_nxt;
  logic [itad_pkg::RADIX_W-1:0]    trial;
  logic [itad_pkg::RADIX_W-1:0]    diff;
  logic                            fits;

  // The partial remainder stays below the divisor, so it fits in one digit.
  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign fits  = (trial >= divisor);
  assign diff  = trial - divisor;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
      rem_nxt = fits ? diff[itad_pkg::DIGIT_W-1:0] : trial[itad_pkg::DIGIT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### hdl/integer_to_ascii_digits_core.sv
// Channel | Direction | tdata (low bit up)                      | tlast
// in_     | slave     | number[VALUE_WIDTH], radix[5], zero pad | -
// out_    | master    | text_char[7], zero bit                  | last_char
//
// An item is accepted, then each digit takes one division in the shared restoring divider
// (one quotient bit per cycle), then a negative base-10 value emits a leading minus sign,
// then each digit character passes through the registered digit-memory read.
// The output register holds a character until taken; a stalled sink holds the
// sequencer. The next item is accepted once the last character sits in that register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the output.
//
// Top level of the integer-to-ASCII converter: sequencer, digit memory and output stage.
// Depends on itad_pkg, itad_div and integer_to_ascii_digits_core_defines.svh.
`default_nettype none
`include "integer_to_ascii_digits_core_defines.svh"

module integer_to_ascii_digits_core #(
  parameter int VALUE_WIDTH = itad_pkg::VALUE_WIDTH_DEF,
  localparam int IN_W = ((VALUE_WIDTH + itad_pkg::RADIX_W + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // number [VALUE_WIDTH-1:0], radix [VALUE_WIDTH+4:VALUE_WIDTH], zero pad above
  input  wire logic [IN_W-1:0]              in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // text_char [6:0], zero in bit 7
  output logic [itad_pkg::OUT_W-1:0]        out_tdata,
  output logic                              out_tlast
);

  localparam int IDX_W = $clog2(VALUE_WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MINUS = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;

  logic [2:0]                       state_r,    state_nxt;
  logic                             start_r,    start_nxt;
  logic                             neg_r,      neg_nxt;
  logic [itad_pkg::RADIX_W-1:0]     radix_r,    radix_nxt;
  logic [VALUE_WIDTH-1:0]           quot_r,     quot_nxt;
  logic [IDX_W-1:0]                 wptr_r,     wptr_nxt;
  logic [IDX_W-1:0]                 idx_r,      idx_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [itad_pkg::CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                             out_last_r, out_last_nxt;
  logic [itad_pkg::DIGIT_W-1:0]     mem_q_r;

  // Digits, least significant first; entries are written before they are read.
  logic [itad_pkg::DIGIT_W-1:0]     digit_mem [VALUE_WIDTH];

  logic                             in_fire;
  logic                             out_free;
  logic [VALUE_WIDTH-1:0]           in_number;
  logic [itad_pkg::RADIX_W-1:0]     in_radix;
  logic [itad_pkg::RADIX_W-1:0]     radix_cl;
  logic                             in_neg;
  logic                             div_done;
  logic [VALUE_WIDTH-1:0]           div_quo;
  logic [itad_pkg::DIGIT_W-1:0]     div_rem;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_number = in_tdata[VALUE_WIDTH-1:0];
  assign in_radix  = in_tdata[VALUE_WIDTH+itad_pkg::RADIX_W-1:VALUE_WIDTH];

  // Bases below two or above sixteen are clamped into range.
  always_comb begin
    if (in_radix < itad_pkg::RADIX_MIN) begin
      radix_cl = itad_pkg::RADIX_MIN;
    end else if (in_radix > itad_pkg::RADIX_MAX) begin
      radix_cl = itad_pkg::RADIX_MAX;
    end else begin
      radix_cl = in_radix;
    end
  end

  // Only base ten prints a sign; other bases see the raw two's-complement pattern.
  assign in_neg = (radix_cl == itad_pkg::RADIX_DEC) && in_number[VALUE_WIDTH-1];

  itad_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (quot_r),
    .divisor   (radix_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    neg_nxt       = neg_r;
    radix_nxt     = radix_r;
    quot_nxt      = quot_r;
    wptr_nxt      = wptr_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          neg_nxt   = in_neg;
          radix_nxt = radix_cl;
          // The most negative value negates to its own pattern, which is the
          // correct unsigned magnitude.
          quot_nxt  = in_neg ? ({VALUE_WIDTH{1'b0}} - in_number) : in_number;
          wptr_nxt  = '0;
          start_nxt = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // A zero value still runs one division, which yields the single digit zero.
        if (div_done) begin
          quot_nxt = div_quo;
          if (div_quo != '0) begin
            wptr_nxt  = wptr_r + 1'b1;
            start_nxt = 1'b1;
          end else begin
            idx_nxt   = wptr_r;
            state_nxt = neg_r ? S_MINUS : S_RD;
          end
        end
      end
      S_MINUS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itad_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itad_pkg::digit_char(mem_q_r);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    radix_r    <= radix_nxt;
    quot_r     <= quot_nxt;
    wptr_r     <= wptr_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit memory: one write port from the divider, one registered read port.
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_done) begin
      digit_mem[wptr_r] <= div_rem;
    end
    if (state_r == S_RD) begin
      mem_q_r <= digit_mem[idx_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(itad_pkg::OUT_W - itad_pkg::CHAR_W){1'b0}}, out_char_r};
  assign out_tlast  = out_last_r;

  `ITAD_ASSERT_IMPLY(a_done_in_div, clk, rst_n, div_done, state_r == S_DIV, "divider finished outside the divide phase")
  `ITAD_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, (state_r == S_DIV) && start_r, "accepted item did not start a division")
  `ITAD_ASSERT_NEXT(a_last_ends_item, clk, rst_n, (state_r == S_WR) && out_free && (idx_r == '0), (state_r == S_IDLE) && out_valid_r && out_last_r, "final character not marked or sequencer not idle")

endmodule

`default_nettype wire
